[src/keyboard_scan_code_decoder_macros.svh]
// assertion macros for the scan code decoder
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef KEYBOARD_SCAN_CODE_DECODER_MACROS_SVH
`define KEYBOARD_SCAN_CODE_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KSCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KSCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kscd_pkg.sv]
// types, constants and helpers for the set 1 scan code decoder
// no dependencies
package kscd_pkg;

  localparam int unsigned MaxHeld   = 5;
  localparam int unsigned HeldIdxW  = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;
  localparam int unsigned HeldCntW  = $clog2(MaxHeld + 1);

  localparam logic [7:0] PrefixByte  = 8'hE0;
  localparam logic [7:0] ReleaseMask = 8'h80;
  localparam logic [7:0] CodeMask    = 8'h7F;
  localparam logic [7:0] ExtendAdd   = 8'h7F;

  localparam logic [7:0] CodeLShift = 8'h2A;
  localparam logic [7:0] CodeRShift = 8'h36;
  localparam logic [7:0] CodeLCtrl  = 8'h1D;
  localparam logic [7:0] CodeRCtrl  = 8'h9C;
  localparam logic [7:0] CodeLAlt   = 8'h38;
  localparam logic [7:0] CodeRAlt   = 8'hB7;

  localparam logic [2:0] ModShift = 3'b001;
  localparam logic [2:0] ModCtrl  = 3'b010;
  localparam logic [2:0] ModAlt   = 3'b100;
  localparam logic [2:0] ModNone  = 3'b000;

  localparam logic KindScan  = 1'b0;
  localparam logic KindFetch = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } kscd_state_e;

  function automatic logic [2:0] modifier_bit(input logic [7:0] code);
    logic [2:0] mod;
    case (code)
      CodeLShift, CodeRShift: mod = ModShift;
      CodeLCtrl,  CodeRCtrl:  mod = ModCtrl;
      CodeLAlt,   CodeRAlt:   mod = ModAlt;
      default:                mod = ModNone;
    endcase
    return mod;
  endfunction

endpackage

[src/keyboard_scan_code_decoder.sv]
// set 1 scan code decoder: top level with held-key list and search sequencer
// depends on kscd_pkg and keyboard_scan_code_decoder_macros.svh
//
// usage: the input channel (in_valid_i / in_stall_o) carries one transaction
// per keyboard byte (kind_i = 0) or per consumer fetch (kind_i = 1). every
// input transaction yields exactly one output transaction (out_valid_o /
// out_stall_i) that shows the decoder state after that item: pending key,
// modifiers, held count, prefix flag and fetched key.
// an item occupies the block from acceptance until its result is loaded into
// the output register; in_stall_o is high meanwhile. fetches, prefix bytes,
// modifier codes and presses of the fetched key go straight to the output
// step. other presses walk the held list through one shared 8-bit comparator,
// one entry a cycle. releases search and then shift later entries down one
// per cycle, the shift picking up where the search stopped. the held list
// is 5 entries deep (MaxHeld).
// the output register lets the next item start while a result still waits;
// if the receiver stalls, the finished item holds in its last step until the
// output register frees up.
// reset clears all control state, the modifiers, the pending key, the
// fetched key and the held count; list entries need no reset.
module keyboard_scan_code_decoder
  import kscd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  scan_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        key_valid_o,
  output logic [10:0] key_code_o,
  output logic [2:0]  modifier_flags_o,
  output logic [2:0]  held_count_o,
  output logic        extend_armed_o,
  output logic [7:0]  fetched_key_o
);

  kscd_state_e state_q, state_d;

  logic [7:0]          held_q [MaxHeld];
  logic [7:0]          held_d [MaxHeld];
  logic [HeldCntW-1:0] held_total_q, held_total_d;
  logic [HeldCntW-1:0] idx_q, idx_d;
  logic [7:0]          code_q, code_d;
  logic                press_q, press_d;
  logic                extend_q, extend_d;
  logic [2:0]          mod_q, mod_d;
  logic                pend_valid_q, pend_valid_d;
  logic [10:0]         pend_code_q, pend_code_d;
  logic [7:0]          taken_q, taken_d;

  logic                out_valid_q, out_valid_d;
  logic                o_key_valid_q;
  logic [10:0]         o_key_code_q;
  logic [2:0]          o_mod_q;
  logic [HeldCntW-1:0] o_count_q;
  logic                o_extend_q;
  logic [7:0]          o_taken_q;
  logic                out_load;

  logic                in_accept;
  logic [7:0]          in_code;
  logic [2:0]          in_mod;
  logic [HeldCntW-1:0] rd_cnt;
  logic [HeldCntW:0]   idx_next;
  logic [7:0]          rd_data;
  logic                match;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // decoded code of the incoming byte, extended when a prefix is armed
  always_comb begin
    in_code = scan_byte_i & CodeMask;
    if (extend_q) begin
      in_code = in_code + ExtendAdd;
    end
    in_mod = modifier_bit(in_code);
  end

  // shared read port and comparator over the held list
  assign idx_next = {1'b0, idx_q} + 1'b1;
  assign rd_cnt   = (state_q == ST_SHIFT) ? idx_next[HeldCntW-1:0] : idx_q;
  always_comb begin
    rd_data = '0;
    if (rd_cnt < HeldCntW'(MaxHeld)) begin
      rd_data = held_q[rd_cnt[HeldIdxW-1:0]];
    end
  end
  assign match = (rd_data == code_q);

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    held_total_d = held_total_q;
    idx_d        = idx_q;
    code_d       = code_q;
    press_d      = press_q;
    extend_d     = extend_q;
    mod_d        = mod_q;
    pend_valid_d = pend_valid_q;
    pend_code_d  = pend_code_q;
    taken_d      = taken_q;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DONE;
          if (kind_i == KindFetch) begin
            if (pend_valid_q) begin
              taken_d = pend_code_q[7:0];
            end
          end else if (scan_byte_i == PrefixByte) begin
            extend_d = 1'b1;
          end else begin
            extend_d = 1'b0;
            code_d   = in_code;
            press_d  = (scan_byte_i & ReleaseMask) == 8'h00;
            idx_d    = '0;
            if (in_mod != ModNone) begin
              if (press_d) begin
                mod_d = mod_q | in_mod;
              end else begin
                mod_d = mod_q & ~in_mod;
              end
            end else if (press_d) begin
              if (in_code == taken_q) begin
                pend_code_d  = {mod_q, in_code};
                pend_valid_d = 1'b1;
              end else begin
                state_d = ST_SEARCH;
              end
            end else begin
              if (pend_valid_q && pend_code_q[7:0] == in_code) begin
                pend_valid_d = 1'b0;
                taken_d      = '0;
              end
              state_d = ST_SEARCH;
            end
          end
        end
      end

      ST_SEARCH: begin
        if (idx_q == held_total_q) begin
          // end of list, code not held
          state_d = ST_DONE;
          if (press_q) begin
            taken_d = '0;
            if (held_total_q < HeldCntW'(MaxHeld)) begin
              held_d[held_total_q[HeldIdxW-1:0]] = code_q;
              held_total_d = held_total_q + 1'b1;
              pend_code_d  = {mod_q, code_q};
              pend_valid_d = 1'b1;
            end else begin
              pend_valid_d = 1'b0;
            end
          end
        end else if (match) begin
          state_d = press_q ? ST_DONE : ST_SHIFT;
        end else begin
          idx_d = idx_next[HeldCntW-1:0];
        end
      end

      ST_SHIFT: begin
        if (idx_next < {1'b0, held_total_q}) begin
          held_d[idx_q[HeldIdxW-1:0]] = rd_data;
          idx_d = idx_next[HeldCntW-1:0];
        end else begin
          held_total_d = held_total_q - 1'b1;
          state_d      = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_total_q <= '0;
      idx_q        <= '0;
      extend_q     <= 1'b0;
      mod_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_code_q  <= '0;
      taken_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_total_q <= held_total_d;
      idx_q        <= idx_d;
      extend_q     <= extend_d;
      mod_q        <= mod_d;
      pend_valid_q <= pend_valid_d;
      pend_code_q  <= pend_code_d;
      taken_q      <= taken_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    code_q  <= code_d;
    press_q <= press_d;
    if (out_load) begin
      o_key_valid_q <= pend_valid_q;
      o_key_code_q  <= pend_valid_q ? pend_code_q : 11'd0;
      o_mod_q       <= mod_q;
      o_count_q     <= held_total_q;
      o_extend_q    <= extend_q;
      o_taken_q     <= taken_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_valid_o      = o_key_valid_q;
  assign key_code_o       = o_key_code_q;
  assign modifier_flags_o = o_mod_q;
  assign held_count_o     = 3'(o_count_q);
  assign extend_armed_o   = o_extend_q;
  assign fetched_key_o    = o_taken_q;

`include "keyboard_scan_code_decoder_macros.svh"

  `KSCD_ASSERT_IMPL(a_total_bound, 1'b1, held_total_q <= HeldCntW'(MaxHeld), "held count overflow")
  `KSCD_ASSERT_IMPL(a_search_idx, state_q == ST_SEARCH, idx_q <= held_total_q, "scan index past list")
  `KSCD_ASSERT_IMPL(a_shift_idx, state_q == ST_SHIFT, idx_q < held_total_q, "shift outside list")
  `KSCD_ASSERT_NEXT(a_accept_busy, in_accept, state_q != ST_IDLE, "accepted item not started")
  `KSCD_ASSERT_IMPL(a_out_rise, $rose(out_valid_q), $past(state_q == ST_DONE), "result without item")

endmodule
